[hdl/scd_pkg.sv]
// ----------------------------------------------------------------------------
// scd_pkg: shared types, codes and character ROMs
// Set-1 scan codes, key event codes, the result record and the two
// character lookup tables (plain and shifted) of the scan code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

  // Scan codes with a special meaning
  localparam logic [7:0] SC_BACKSPACE    = 8'h0e;
  localparam logic [7:0] SC_TAB          = 8'h0f;
  localparam logic [7:0] SC_ENTER        = 8'h1c;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2a;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'haa;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hb6;
  localparam logic [7:0] SC_CAPS         = 8'h3a;
  localparam logic [7:0] SC_NUM          = 8'h45;
  localparam logic [7:0] SC_SCROLL       = 8'h46;

  // Letter range and upper-to-lower case offset
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_GAP     = 8'h20;

  // Key event codes
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_CHAR      = 3'd1;
  localparam logic [2:0] EV_BACKSPACE = 3'd2;
  localparam logic [2:0] EV_ENTER     = 3'd3;
  localparam logic [2:0] EV_TAB       = 3'd4;

  // Lock bit positions
  localparam int LOCK_SCROLL = 0;
  localparam int LOCK_NUM    = 1;
  localparam int LOCK_CAPS   = 2;

  // Shift bit positions
  localparam int SHIFT_LEFT  = 0;
  localparam int SHIFT_RIGHT = 1;

  // One result item, highest field first so that char_code is in the low bits
  typedef struct packed {
    logic [1:0] shift_state;
    logic [2:0] led_state;
    logic       led_changed;
    logic [2:0] key_event;
    logic [7:0] char_code;
  } scd_result_t;

  localparam int RESULT_W = $bits(scd_result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

  // Character ROM: a make code index, plain or shifted table
  function automatic logic [7:0] scd_rom(input logic [6:0] idx, input logic shifted);
    logic [7:0] ch;
    begin
      ch = 8'h00;
      case (idx)
        7'h01: ch = shifted ? 8'h7e : 8'h60;
        7'h02: ch = shifted ? 8'h21 : 8'h31;
        7'h03: ch = shifted ? 8'h40 : 8'h32;
        7'h04: ch = shifted ? 8'h23 : 8'h33;
        7'h05: ch = shifted ? 8'h24 : 8'h34;
        7'h06: ch = shifted ? 8'h25 : 8'h35;
        7'h07: ch = shifted ? 8'h5e : 8'h36;
        7'h08: ch = shifted ? 8'h26 : 8'h37;
        7'h09: ch = shifted ? 8'h2a : 8'h38;
        7'h0a: ch = shifted ? 8'h28 : 8'h39;
        7'h0b: ch = shifted ? 8'h29 : 8'h30;
        7'h0c: ch = shifted ? 8'h5f : 8'h2d;
        7'h0d: ch = shifted ? 8'h2b : 8'h3d;
        7'h10: ch = 8'h51;
        7'h11: ch = 8'h57;
        7'h12: ch = 8'h45;
        7'h13: ch = 8'h52;
        7'h14: ch = 8'h54;
        7'h15: ch = 8'h59;
        7'h16: ch = 8'h55;
        7'h17: ch = 8'h49;
        7'h18: ch = 8'h4f;
        7'h19: ch = 8'h50;
        7'h1a: ch = shifted ? 8'h7b : 8'h5b;
        7'h1b: ch = shifted ? 8'h7d : 8'h5d;
        7'h1e: ch = 8'h41;
        7'h1f: ch = 8'h53;
        7'h20: ch = 8'h44;
        7'h21: ch = 8'h46;
        7'h22: ch = 8'h47;
        7'h23: ch = 8'h48;
        7'h24: ch = 8'h4a;
        7'h25: ch = 8'h4b;
        7'h26: ch = 8'h4c;
        7'h27: ch = shifted ? 8'h3a : 8'h3b;
        7'h28: ch = shifted ? 8'h22 : 8'h27;
        7'h2b: ch = shifted ? 8'h7c : 8'h5c;
        7'h2c: ch = 8'h5a;
        7'h2d: ch = 8'h58;
        7'h2e: ch = 8'h43;
        7'h2f: ch = 8'h56;
        7'h30: ch = 8'h42;
        7'h31: ch = 8'h4e;
        7'h32: ch = 8'h4d;
        7'h33: ch = shifted ? 8'h3c : 8'h2c;
        7'h34: ch = shifted ? 8'h3e : 8'h2e;
        7'h35: ch = shifted ? 8'h3f : 8'h2f;
        7'h37: ch = 8'h2a;
        7'h39: ch = 8'h20;
        7'h47: ch = 8'h37;
        7'h48: ch = 8'h38;
        7'h49: ch = 8'h39;
        7'h4a: ch = 8'h2d;
        7'h4b: ch = 8'h34;
        7'h4c: ch = 8'h35;
        7'h4d: ch = 8'h36;
        7'h4e: ch = 8'h2b;
        7'h4f: ch = 8'h31;
        7'h50: ch = 8'h32;
        7'h51: ch = 8'h33;
        7'h52: ch = 8'h30;
        7'h53: ch = 8'h2e;
        7'h73: ch = shifted ? 8'h5f : 8'h5c;
        7'h7d: ch = shifted ? 8'h7c : 8'h5c;
        default: ch = 8'h00;
      endcase
      return ch;
    end
  endfunction

endpackage

`default_nettype wire

[hdl/scancode_to_ascii_decoder_top.sv]
// Pipeline: an accepted item passes the input register, then the result register, on to out_*;
//   two register stages in all.
// Throughput: one item per cycle while out_tready does not hold the full result register;
//   the combinational ROM lookup and flag update lie between the two registers.
// Reset (rst_n low, synchronous): both stages empty, shift state and lock bits cleared.
// A cfg write loads the lock bits at once.
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_top: set-1 scan code to character decoder
// Stream in scan code bytes, stream out characters, key events and the
// lock LED and shift state after each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_to_ascii_decoder_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [2:0]                    cfg_wr_data,  // initial_leds
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,     // [7:0] scan_code
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [7:0] char_code, [10:8] key_event, [11] led_changed, [14:12] led_state,
  // [16:15] shift_state, [23:17] zero
  output logic [scd_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import scd_pkg::*;

  logic        in_valid_r;
  logic [7:0]  in_code_r;
  logic        out_valid_r;
  scd_result_t out_res_r;
  logic [1:0]  shift_r;
  logic [2:0]  lock_r;
  logic [1:0]  shift_nxt;
  logic [2:0]  lock_nxt;
  logic        advance;
  logic        in_fire;
  scd_result_t res;

  // Handshake: result register frees when empty or taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // Translate the held item
  scd_decode u_decode (
    .code_i  (in_code_r),
    .shift_i (shift_r),
    .lock_i  (lock_r),
    .res_o   (res)
  );

  // Next state: commit the item's effect as it moves on; cfg loads the locks
  always_comb begin
    shift_nxt = shift_r;
    lock_nxt  = lock_r;
    if (advance && in_valid_r) begin
      shift_nxt = res.shift_state;
      lock_nxt  = res.led_state;
    end
    if (cfg_wr_en) begin
      lock_nxt = cfg_wr_data;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      shift_r     <= '0;
      lock_r      <= '0;
    end else begin
      shift_r <= shift_nxt;
      lock_r  <= lock_nxt;
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_code_r <= in_tdata;
    end
    if (advance && in_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res_r};

`ifndef SYNTH
  // The delivered LED state is the lock state the block carries forward
  a_led_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_valid_r && !cfg_wr_en) |=> (out_res_r.led_state == lock_r))
    else $error("result led_state differs from held lock bits");

  // The delivered shift state is the shift state the block carries forward
  a_shift_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_valid_r) |=> (out_res_r.shift_state == shift_r))
    else $error("result shift_state differs from held shift bits");

  // A lock toggle never carries a character
  a_lock_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.led_changed) |->
      ((out_res_r.char_code == 8'h00) && (out_res_r.key_event == EV_NONE)))
    else $error("lock toggle result carries a character");

  // A printable event always has a character
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.key_event == EV_CHAR)) |-> (out_res_r.char_code != 8'h00))
    else $error("printable event without a character");

  // Input stalls only when both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_valid_r && out_valid_r))
    else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire

[hdl/scd_decode.sv]
// ----------------------------------------------------------------------------
// scd_decode: single scan code translation
// Looks up the character, classifies the key event and works out the
// shift and lock state after the scan code, from the state before it.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_decode (
  input  wire logic [7:0]          code_i,
  input  wire logic [1:0]          shift_i,
  input  wire logic [2:0]          lock_i,
  output scd_pkg::scd_result_t     res_o
);
  import scd_pkg::*;

  logic       shifted;
  logic       caps;
  logic [7:0] rom_ch;
  logic [7:0] ch;
  logic [2:0] ev;
  logic [1:0] shift_nxt;
  logic [2:0] lock_nxt;
  logic       changed;

  // Look up the character; break codes give none
  always_comb begin
    shifted = |shift_i;
    caps    = lock_i[LOCK_CAPS];
    rom_ch  = code_i[7] ? 8'h00 : scd_rom(code_i[6:0], shifted);
    ch      = rom_ch;
    if ((rom_ch >= CHAR_UPPER_A) && (rom_ch <= CHAR_UPPER_Z) && (caps == shifted)) begin
      ch = rom_ch + CASE_GAP;
    end
  end

  // Classify the key event
  always_comb begin
    ev = (ch != 8'h00) ? EV_CHAR : EV_NONE;
    unique case (code_i)
      SC_BACKSPACE: ev = EV_BACKSPACE;
      SC_ENTER:     ev = EV_ENTER;
      SC_TAB:       ev = EV_TAB;
      default:      ;
    endcase
  end

  // Update shift and lock state
  always_comb begin
    shift_nxt = shift_i;
    lock_nxt  = lock_i;
    changed   = 1'b0;
    unique case (code_i)
      SC_LSHIFT_MAKE:  shift_nxt[SHIFT_LEFT]  = 1'b1;
      SC_RSHIFT_MAKE:  shift_nxt[SHIFT_RIGHT] = 1'b1;
      SC_LSHIFT_BREAK: shift_nxt[SHIFT_LEFT]  = 1'b0;
      SC_RSHIFT_BREAK: shift_nxt[SHIFT_RIGHT] = 1'b0;
      SC_CAPS: begin
        lock_nxt[LOCK_CAPS] = ~lock_i[LOCK_CAPS];
        changed = 1'b1;
      end
      SC_NUM: begin
        lock_nxt[LOCK_NUM] = ~lock_i[LOCK_NUM];
        changed = 1'b1;
      end
      SC_SCROLL: begin
        lock_nxt[LOCK_SCROLL] = ~lock_i[LOCK_SCROLL];
        changed = 1'b1;
      end
      default: ;
    endcase
  end

  // Assemble the result item
  always_comb begin
    res_o.char_code   = ch;
    res_o.key_event   = ev;
    res_o.led_changed = changed;
    res_o.led_state   = lock_nxt;
    res_o.shift_state = shift_nxt;
  end

endmodule

`default_nettype wire
